### rtl/tba_pkg.sv
package tba_pkg;

   localparam int TS_W           = 32;
   localparam int VAL_W          = 32;
   localparam int LEN_W          = 17;
   localparam int LIMIT_W        = 6;
   localparam int OP_W           = 2;
   localparam int CSR_IDX_W      = 1;
   localparam int MAX_FILL_DEF   = 62;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [LEN_W-1:0] RESET_BUCKET_LENGTH = LEN_W'(60 * 10);

   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_NEW    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_LIMIT    = 1'd1;

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_NEW,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [TS_W-1:0]         timestamp;
      logic signed [VAL_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [TS_W-1:0]         bucket_start;
      logic signed [VAL_W-1:0] mean_value;
      logic                    is_fill;
      logic                    last;
   } rsp_type;

endpackage

### rtl/tba_fifo.sv
module tba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### rtl/tba_front.sv
module tba_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic [tba_pkg::OP_W-1:0]     req_operation,
   input  logic [tba_pkg::TS_W-1:0]     req_timestamp,
   input  logic signed [tba_pkg::VAL_W-1:0] req_sample,
   output logic                         req_full,
   output tba_pkg::item_type            item,
   output logic                         item_empty,
   input  logic                         item_pop
);
   import tba_pkg::*;

   item_type in_item;
   logic     known_op;
   logic     q_full;

   // classify; the unused code is accepted and dropped here
   always_comb begin
      in_item.timestamp = req_timestamp;
      in_item.sample    = req_sample;
      in_item.kind      = KIND_SAMPLE;
      known_op          = 1'b1;
      case (req_operation)
         OP_SAMPLE: in_item.kind = KIND_SAMPLE;
         OP_NEW:    in_item.kind = KIND_NEW;
         OP_CLOSE:  in_item.kind = KIND_CLOSE;
         default:   known_op     = 1'b0;
      endcase
   end

   assign req_full = q_full;

   tba_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (2)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push && known_op),
      .wdata (in_item),
      .full  (q_full),
      .pop   (item_pop),
      .rdata (item),
      .empty (item_empty)
   );

endmodule

### rtl/tba_div.sv
module tba_div #(
   parameter int DW = 48,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW);

   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dsr_ff;
   logic [CW-1:0] step_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   trial;
   logic [VW:0]   diff;

   assign trial     = {rem_ff, quo_ff[DW-1]};
   assign diff      = trial - {1'b0, dsr_ff};
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            step_ff <= CW'(DW - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // one quotient bit per cycle, restoring
            if (!diff[VW]) begin
               rem_ff <= diff[VW-1:0];
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= trial[VW-1:0];
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

### rtl/tba_back.sv
module tba_back #(
   parameter int COUNT_BITS = tba_pkg::COUNT_BITS_DEF,
   parameter int MAX_FILL   = tba_pkg::MAX_FILL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tba_pkg::item_type             item,
   input  logic                          item_empty,
   output logic                          item_pop,
   input  logic [tba_pkg::LEN_W-1:0]     len,
   input  logic [tba_pkg::LIMIT_W-1:0]   limit,
   output tba_pkg::rsp_type              rsp,
   output logic                          rsp_push,
   input  logic                          rsp_full
);
   import tba_pkg::*;

   localparam int SUM_W = VAL_W + COUNT_BITS;
   localparam int VW    = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MEAN,
      S_ALIGN,
      S_GAP,
      S_EMIT,
      S_FILL,
      S_FINISH
   } state_type;

   state_type               state_ff;
   logic [TS_W-1:0]         ts_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [TS_W-1:0]         obs_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [COUNT_BITS-1:0]   cnt_ff;
   logic                    open_ff;
   logic signed [VAL_W-1:0] mean_ff;
   logic [TS_W-1:0]         ns_ff;
   logic [TS_W:0]           ft_ff;
   logic [LIMIT_W-1:0]      k_ff;
   logic                    emit_ff;
   logic                    open_new_ff;
   logic                    gap_ff;
   logic                    close_ff;
   logic                    fill_go_ff;
   logic                    div_start_ff;
   logic [SUM_W-1:0]        div_a_ff;
   logic [VW-1:0]           div_b_ff;

   logic                    div_done;
   logic [SUM_W-1:0]        div_q;
   logic [VW-1:0]           div_r;
   logic                    in_bucket;
   logic                    has_pend;
   logic                    start_new;
   logic [SUM_W-1:0]        sum_abs;
   logic [TS_W-1:0]         ns_calc;
   logic [TS_W:0]           ns_gap;
   logic [LIMIT_W-1:0]      limit_eff;
   logic                    fill_last;
   logic [TS_W+1:0]         ft_next;

   assign in_bucket = (item.timestamp >= obs_ff)
                   && ((item.timestamp - obs_ff) < TS_W'(len));
   assign has_pend  = open_ff && (cnt_ff != '0);
   assign start_new = (item.kind == KIND_NEW) || !open_ff;
   assign sum_abs   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign ns_calc   = ts_ff - TS_W'(div_r);
   assign ns_gap    = {1'b0, ns_calc} - {1'b0, obs_ff};
   assign limit_eff = (limit > LIMIT_W'(MAX_FILL)) ? LIMIT_W'(MAX_FILL) : limit;
   assign ft_next   = {1'b0, ft_ff} + (TS_W+2)'(len);
   assign fill_last = (ft_next >= (TS_W+2)'(ns_ff)) || (k_ff == LIMIT_W'(MAX_FILL - 1));
   assign item_pop  = (state_ff == S_IDLE) && !item_empty;

   always_comb begin
      rsp_push = 1'b0;
      rsp.mean_value = mean_ff;
      rsp.bucket_start = obs_ff;
      rsp.is_fill = 1'b0;
      rsp.last = !fill_go_ff;
      case (state_ff)
         S_EMIT: rsp_push = emit_ff && !rsp_full;
         S_FILL: begin
            rsp_push = !rsp_full;
            rsp.bucket_start = ft_ff[TS_W-1:0];
            rsp.is_fill = 1'b1;
            rsp.last = fill_last;
         end
         default: rsp_push = 1'b0;
      endcase
   end

   tba_div #(
      .DW (SUM_W),
      .VW (VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= 1'b0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         obs_ff       <= '0;
         div_start_ff <= 1'b0;
         emit_ff      <= 1'b0;
         open_new_ff  <= 1'b0;
         gap_ff       <= 1'b0;
         close_ff     <= 1'b0;
         fill_go_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!item_empty) begin
                  ts_ff       <= item.timestamp;
                  val_ff      <= item.sample;
                  emit_ff     <= has_pend;
                  fill_go_ff  <= 1'b0;
                  gap_ff      <= 1'b0;
                  close_ff    <= (item.kind == KIND_CLOSE);
                  open_new_ff <= (item.kind != KIND_CLOSE);
                  if (item.kind == KIND_SAMPLE && open_ff && in_bucket) begin
                     open_new_ff <= 1'b0;
                     // saturated bucket ignores further samples
                     if (cnt_ff != '1) begin
                        sum_ff <= sum_ff + SUM_W'(item.sample);
                        cnt_ff <= cnt_ff + 1'b1;
                     end
                  end else begin
                     gap_ff <= (item.kind == KIND_SAMPLE) && !start_new;
                     if (has_pend) begin
                        div_a_ff     <= sum_abs;
                        div_b_ff     <= VW'(cnt_ff);
                        div_start_ff <= 1'b1;
                        state_ff     <= S_MEAN;
                     end else if (item.kind != KIND_CLOSE) begin
                        div_a_ff     <= SUM_W'(item.timestamp);
                        div_b_ff     <= VW'(len);
                        div_start_ff <= 1'b1;
                        state_ff     <= S_ALIGN;
                     end else begin
                        state_ff <= S_FINISH;
                     end
                  end
               end
            end
            S_MEAN: begin
               if (div_done) begin
                  mean_ff <= sum_ff[SUM_W-1] ? VAL_W'(-div_q) : VAL_W'(div_q);
                  if (open_new_ff) begin
                     div_a_ff     <= SUM_W'(ts_ff);
                     div_b_ff     <= VW'(len);
                     div_start_ff <= 1'b1;
                     state_ff     <= S_ALIGN;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_ALIGN: begin
               if (div_done) begin
                  ns_ff <= ns_calc;
                  if (gap_ff && (ns_calc > obs_ff) && (ns_gap > (TS_W+1)'(len))) begin
                     // whole buckets between the old bucket's end and the new start
                     div_a_ff     <= SUM_W'(ns_gap - (TS_W+1)'(len));
                     div_b_ff     <= VW'(len);
                     div_start_ff <= 1'b1;
                     state_ff     <= S_GAP;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_GAP: begin
               if (div_done) begin
                  fill_go_ff <= (MAX_FILL != 0) && (div_q <= SUM_W'(limit_eff));
                  ft_ff      <= {1'b0, obs_ff} + (TS_W+1)'(len);
                  k_ff       <= '0;
                  state_ff   <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!emit_ff) begin
                  state_ff <= S_FINISH;
               end else if (!rsp_full) begin
                  state_ff <= fill_go_ff ? S_FILL : S_FINISH;
               end
            end
            S_FILL: begin
               if (!rsp_full) begin
                  ft_ff <= ft_next[TS_W:0];
                  k_ff  <= k_ff + 1'b1;
                  if (fill_last) begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (open_new_ff) begin
                  obs_ff  <= ns_ff;
                  sum_ff  <= SUM_W'(val_ff);
                  cnt_ff  <= COUNT_BITS'(1);
                  open_ff <= 1'b1;
               end else if (close_ff) begin
                  sum_ff  <= '0;
                  cnt_ff  <= '0;
                  open_ff <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/time_bucket_averager_gap_fill.sv
// Time-bucket averager with gap fill.
// Input queue (req_push / req_full): operation, timestamp, Q16.16 sample.
// Result queue (rsp_empty / rsp_pop): bucket_start, mean_value, is_fill, last;
// the oldest result waits on the rsp_ ports while rsp_empty is low.
// Configuration (csr_valid / csr_ready, always ready): index 0 bucket_length,
// index 1 fill_limit; write only while the block is idle.
// The shared radix-2 divider serves every division. Back-end work per item:
// a sample in the open bucket only accumulates, a close with nothing open
// needs no division, the first sample of a series or a flushing close takes
// one divider pass, a new series or a move to the next bucket takes two
// passes, and skipped buckets take three passes followed by one result per
// fill. An accepted item reaches the back end through the registered input
// queue.
// Items after the current one wait in a two-entry input queue; results wait
// in a two-entry output queue. When the receiver stalls, the output queue
// fills, result emission holds, then the input queue fills and req_full rises.
// Reset (synchronous) restores bucket_length 600, fill_limit 0, no series
// open and empties both queues.
module time_bucket_averager_gap_fill #(
   parameter int COUNT_BITS = tba_pkg::COUNT_BITS_DEF,
   parameter int MAX_FILL   = tba_pkg::MAX_FILL_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [tba_pkg::OP_W-1:0]          req_operation,
   input  logic [tba_pkg::TS_W-1:0]          req_timestamp,
   input  logic signed [tba_pkg::VAL_W-1:0]  req_sample,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [tba_pkg::TS_W-1:0]          rsp_bucket_start,
   output logic signed [tba_pkg::VAL_W-1:0]  rsp_mean_value,
   output logic                              rsp_is_fill,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tba_pkg::LEN_W-1:0]         csr_data
);
   import tba_pkg::*;

   logic [LEN_W-1:0]   len_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [LEN_W-1:0]   len_eff;
   item_type           item;
   logic               item_empty;
   logic               item_pop;
   rsp_type            back_rsp;
   rsp_type            out_rsp;
   logic               back_push;
   logic               out_full;

   assign csr_ready = 1'b1;
   // zero length acts as one second
   assign len_eff   = (len_ff == '0) ? LEN_W'(1) : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= RESET_BUCKET_LENGTH;
         limit_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BUCKET_LENGTH: len_ff   <= csr_data;
            CSR_FILL_LIMIT:    limit_ff <= csr_data[LIMIT_W-1:0];
            default:           len_ff   <= len_ff;
         endcase
      end
   end

   tba_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_operation (req_operation),
      .req_timestamp (req_timestamp),
      .req_sample    (req_sample),
      .req_full      (req_full),
      .item          (item),
      .item_empty    (item_empty),
      .item_pop      (item_pop)
   );

   tba_back #(
      .COUNT_BITS (COUNT_BITS),
      .MAX_FILL   (MAX_FILL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .len        (len_eff),
      .limit      (limit_ff),
      .rsp        (back_rsp),
      .rsp_push   (back_push),
      .rsp_full   (out_full)
   );

   tba_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (back_push),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rsp),
      .empty (rsp_empty)
   );

   assign rsp_bucket_start = out_rsp.bucket_start;
   assign rsp_mean_value   = out_rsp.mean_value;
   assign rsp_is_fill      = out_rsp.is_fill;
   assign rsp_last         = out_rsp.last;

endmodule

### sim/time_bucket_averager_gap_fill_checker.sv
module time_bucket_averager_gap_fill_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_full,
   input  logic [tba_pkg::OP_W-1:0]          req_operation,
   input  logic [tba_pkg::TS_W-1:0]          req_timestamp,
   input  logic signed [tba_pkg::VAL_W-1:0]  req_sample,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  logic [tba_pkg::TS_W-1:0]          rsp_bucket_start,
   input  logic signed [tba_pkg::VAL_W-1:0]  rsp_mean_value,
   input  logic                              rsp_is_fill,
   input  logic                              rsp_last,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [tba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tba_pkg::LEN_W-1:0]         csr_data,
   output int                                fail_count,
   output int                                pending_count,
   output int                                item_count,
   output int                                bucket_count,
   output int                                fill_count
);
   import tba_pkg::*;

   localparam int           MAX_FILL  = MAX_FILL_DEF;
   localparam longint       COUNT_TOP = (longint'(1) << COUNT_BITS_DEF) - 1;

   logic [LEN_W-1:0]   bucket_len_reg;
   logic [LIMIT_W-1:0] fill_limit_reg;

   longint unsigned    cur_bucket_start;
   longint             bucket_sum;
   longint             bucket_samples;
   bit                 series_live;

   rsp_type            expected_buckets[$];

   task automatic report(input string what, input longint unsigned want,
                         input longint unsigned got);
      $display("MISMATCH t=%0t %s: expected %0h got %0h", $time, what, want, got);
      fail_count++;
   endtask

   function automatic rsp_type make_bucket(input longint unsigned start,
                                           input longint mean, input bit fill);
      rsp_type r;
      r.bucket_start = start[31:0];
      r.mean_value   = mean[31:0];
      r.is_fill      = fill;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic longint bucket_mean();
      if (bucket_samples == 0) return 0;
      return bucket_sum / bucket_samples;
   endfunction

   // Emit the open bucket if it holds samples, then clear the accumulator.
   task automatic close_bucket(inout rsp_type outq[$]);
      if (series_live && bucket_samples != 0)
         outq = {outq, make_bucket(cur_bucket_start, bucket_mean(), 1'b0)};
      bucket_sum     = 0;
      bucket_samples = 0;
   endtask

   task automatic start_bucket(input longint unsigned ts, input longint val,
                               input longint unsigned len);
      cur_bucket_start = ts - (ts % len);
      bucket_sum       = val;
      bucket_samples   = 1;
      series_live      = 1'b1;
   endtask

   task automatic average_buckets(input logic [OP_W-1:0] op,
                                  input logic [TS_W-1:0] ts_in,
                                  input logic signed [VAL_W-1:0] val_in);
      rsp_type            outq[$];
      longint unsigned    len, lim, ts, old_start, new_start, first_fill, ft;
      longint             val, old_mean;
      int                 k;
      // unused operation code: drop, no state change
      if (!(op inside {OP_SAMPLE, OP_NEW, OP_CLOSE})) return;
      len = (bucket_len_reg == 0) ? 1 : bucket_len_reg;
      lim = (fill_limit_reg > MAX_FILL) ? MAX_FILL : fill_limit_reg;
      ts  = ts_in;
      val = val_in;
      if (op == OP_CLOSE) begin
         close_bucket(outq);
         series_live = 1'b0;
      end else if (op == OP_NEW || !series_live) begin
         close_bucket(outq);
         start_bucket(ts, val, len);
      end else if (ts >= cur_bucket_start && ts - cur_bucket_start < len) begin
         // saturated bucket drops further samples
         if (bucket_samples < COUNT_TOP) begin
            bucket_sum += val;
            bucket_samples++;
         end
      end else begin
         old_start = cur_bucket_start;
         old_mean  = bucket_mean();
         new_start = ts - (ts % len);
         close_bucket(outq);
         if (new_start > old_start && new_start - old_start > len) begin
            first_fill = old_start + len;
            if ((new_start - first_fill) / len <= lim) begin
               k = 0;
               for (ft = first_fill; ft < new_start && k < MAX_FILL; ft += len) begin
                  outq = {outq, make_bucket(ft, old_mean, 1'b1)};
                  k++;
               end
            end
         end
         start_bucket(ts, val, len);
      end
      if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
      expected_buckets = {expected_buckets, outq};
   endtask

   assign pending_count = expected_buckets.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bucket_len_reg   = RESET_BUCKET_LENGTH;
         fill_limit_reg   = '0;
         cur_bucket_start = 0;
         bucket_sum       = 0;
         bucket_samples   = 0;
         series_live      = 1'b0;
         fail_count       = 0;
         item_count       = 0;
         bucket_count     = 0;
         fill_count       = 0;
         expected_buckets.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            bucket_count++;
            if (rsp_is_fill) fill_count++;
            if (expected_buckets.size() == 0) begin
               report("unexpected result", 0, rsp_bucket_start);
            end else begin
               want = expected_buckets.pop_front();
               if (want.bucket_start !== rsp_bucket_start)
                  report("bucket_start", want.bucket_start, rsp_bucket_start);
               if (want.mean_value !== rsp_mean_value)
                  report("mean_value", want.mean_value, rsp_mean_value);
               if (want.is_fill !== rsp_is_fill)
                  report("is_fill", want.is_fill, rsp_is_fill);
               if (want.last !== rsp_last)
                  report("last", want.last, rsp_last);
            end
         end
         if (req_push && !req_full) begin
            item_count++;
            average_buckets(req_operation, req_timestamp, req_sample);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BUCKET_LENGTH) bucket_len_reg = csr_data;
            else if (csr_index == CSR_FILL_LIMIT) fill_limit_reg = csr_data[LIMIT_W-1:0];
         end
      end
   end

endmodule

### sim/time_bucket_averager_gap_fill_tb.sv
module time_bucket_averager_gap_fill_tb;
   import tba_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 400;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [OP_W-1:0]          req_operation = OP_SAMPLE;
   logic [TS_W-1:0]          req_timestamp = '0;
   logic signed [VAL_W-1:0]  req_sample = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [TS_W-1:0]          rsp_bucket_start;
   logic signed [VAL_W-1:0]  rsp_mean_value;
   logic                     rsp_is_fill;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_BUCKET_LENGTH;
   logic [LEN_W-1:0]         csr_data = '0;

   int fail_count, pending_count, item_count, bucket_count, fill_count;

   bit hold_req  = 1'b0;
   bit hold_done = 1'b0;
   bit no_gaps  = 1'b0;
   int burst_left = 0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   time_bucket_averager_gap_fill DUT (.*);

   time_bucket_averager_gap_fill_checker checker_i (.*);

   // Receiver: long hold-off on request, otherwise a rotating stall pattern.
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_pop <= 1'b0;
            repeat (600) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            cyc++;
            case ((cyc / 97) % 4)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= ($urandom_range(0, 1) == 1);
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= ((cyc % 16) < 5);
            endcase
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_valid)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts,
                            input logic signed [VAL_W-1:0] val);
      int gap;
      if (burst_left == 0 && !no_gaps) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_push      <= 1'b1;
      req_operation <= op;
      req_timestamp <= ts;
      req_sample    <= val;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Drain: hold input until every expected result has arrived and the block settles.
   task automatic drain();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int len_val, input int lim_val);
      drain();
      write_csr(CSR_BUCKET_LENGTH, LEN_W'(len_val));
      write_csr(CSR_FILL_LIMIT, LEN_W'(lim_val));
   endtask

   initial begin
      int len_set[5];
      int lim_set[5];
      logic [TS_W-1:0]  ts;
      logic [OP_W-1:0]  op;
      logic signed [VAL_W-1:0] val;
      int len, lim, r;
      bit live;

      len_set = '{1, 600, 86400, 0, 7};
      lim_set = '{63, 0, 5, 62, 3};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset config, sample with no series open, extremes
      push_item(OP_CLOSE, 32'd0, 32'sd0);
      push_item(OP_SAMPLE, 32'd0, 32'sh7FFFFFFF);
      push_item(OP_SAMPLE, 32'd599, 32'sh7FFFFFFF);
      push_item(OP_SAMPLE, 32'd1200, 32'sh80000000);
      push_item(OP_SAMPLE, 32'd1000, -32'sd3);
      push_item(OP_SAMPLE, 32'd1800, 32'sd7);
      push_item(OP_NEW, 32'hFFFFFFFF, 32'sh80000000);
      push_item(OP_CLOSE, 32'hFFFFFFFF, 32'sd0);
      push_item(OP_CLOSE, 32'd5, 32'sd0);

      // fills; change length in the middle of a series
      configure(10, 63);
      push_item(OP_NEW, 32'd100, 32'sd50);
      push_item(OP_SAMPLE, 32'd105, -32'sd7);
      push_item(OP_SAMPLE, 32'd120, 32'sd9);
      push_item(OP_SAMPLE, 32'd160, 32'sd11);
      push_item(OP_SAMPLE, 32'd900, 32'sd13);
      push_item(OP_SAMPLE, 32'd905, 32'sd13);
      configure(3, 2);
      push_item(OP_SAMPLE, 32'd925, -32'sd100);
      push_item(OP_SAMPLE, 32'd960, 32'sd1);
      push_item(OP_SAMPLE, 32'd972, 32'sd1);
      configure(0, 63);
      push_item(OP_NEW, 32'hFFFFFF00, 32'sd5);
      push_item(OP_SAMPLE, 32'hFFFFFFFF, 32'sd6);
      push_item(OP_CLOSE, 32'd0, 32'sd0);

      // random phases of well-formed series with some noise
      live = 1'b0;
      ts = $urandom;
      for (int p = 0; p < 5; p++) begin
         configure(len_set[p], lim_set[p]);
         len = (len_set[p] == 0) ? 1 : len_set[p];
         lim = lim_set[p];
         if (p == 1) hold_req = 1'b1;
         no_gaps = (p == 2);
         for (int i = 0; i < 36; i++) begin
            r   = $urandom_range(0, 19);
            val = ($urandom_range(0, 3) == 0) ? $signed(32'($urandom_range(0, 200)) - 100)
                                              : $signed($urandom);
            if (!live || r == 0) begin
               op = ($urandom_range(0, 5) == 0) ? OP_SAMPLE : OP_NEW;
               ts = $urandom;
               live = 1'b1;
            end else if (r == 1) begin
               op = OP_CLOSE;
               live = 1'b0;
            end else begin
               op = OP_SAMPLE;
               if (r < 12) ts = ts + $urandom_range(0, len - 1);
               else if (r < 18) ts = ts + $urandom_range(len, len * (lim + 3));
               else ts = ts - $urandom_range(1, 3 * len);
            end
            push_item(op, ts, val);
         end
      end
      no_gaps = 1'b0;
      drain();

      $display("Covered %0d items, %0d buckets emitted (%0d gap fills).",
               item_count, bucket_count, fill_count);
      $display("Settings swept bucket length 0..86400 and fill limit 0..63.");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
